// ----- rtl/pcas_pkg.sv -----
// shared types, constants and helpers for the ascii shade core
package pcas_pkg;

    localparam int COORD_BITS    = 12;
    localparam int MAX_COLUMNS   = 256;
    localparam int MAX_CELL_DIM  = 64;

    localparam int DIM_BITS      = $clog2(MAX_CELL_DIM) + 1;
    localparam int COL_BITS      = $clog2(MAX_COLUMNS);
    localparam int GRID_BITS     = COL_BITS + 1;
    localparam int OFFSET_BITS   = 8;
    localparam int GRAY_BITS     = 8;
    localparam int SUM_BITS      = 20;
    localparam int CNT_BITS      = 13;
    localparam int AREA_BITS     = 2 * DIM_BITS;
    localparam int CHAR_BITS     = 7;
    localparam int CELL_IDX_BITS = 8;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 9;

    localparam logic [SUM_BITS-1:0]  SHADE_STEP   = SUM_BITS'(63);
    localparam logic [CHAR_BITS-1:0] CHAR_OUTLINE = CHAR_BITS'(8'h23);

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_CELL_WIDTH     = 3'd0,
        REG_CELL_HEIGHT    = 3'd1,
        REG_GRID_COLUMNS   = 3'd2,
        REG_GRID_ROWS      = 3'd3,
        REG_OFFSET_X       = 3'd4,
        REG_OFFSET_Y       = 3'd5,
        REG_OUTLINE_ENABLE = 3'd6
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_READ,
        ST_THRESH,
        ST_EMIT
    } state_t;

    // clamped configuration as seen by the datapath
    typedef struct packed {
        logic [DIM_BITS-1:0]    cell_w;
        logic [DIM_BITS-1:0]    cell_h;
        logic [GRID_BITS-1:0]   cols;
        logic [GRID_BITS-1:0]   rows;
        logic [OFFSET_BITS-1:0] off_x;
        logic [OFFSET_BITS-1:0] off_y;
        logic                   outline;
    } cfg_t;

    // one accumulator entry per grid column
    typedef struct packed {
        logic [SUM_BITS-1:0] sum;
        logic [CNT_BITS-1:0] cnt;
    } acc_t;

    function automatic logic [CHAR_BITS-1:0] shade_code(input logic [1:0] idx);
        logic [CHAR_BITS-1:0] code;
        case (idx)
            2'd0:    code = CHAR_BITS'(8'h2E);
            2'd1:    code = CHAR_BITS'(8'h3A);
            2'd2:    code = CHAR_BITS'(8'h6F);
            default: code = CHAR_BITS'(8'h4F);
        endcase
        return code;
    endfunction

endpackage

// ----- rtl/pcas_cfg.sv -----
// configuration registers with range clamping
module pcas_cfg (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [pcas_pkg::CFG_IDX_BITS-1:0]   cfg_index,
    input  logic [pcas_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    output pcas_pkg::cfg_t                      cfg
);
    import pcas_pkg::*;

    logic [DIM_BITS-1:0]    cell_w_reg;
    logic [DIM_BITS-1:0]    cell_h_reg;
    logic [GRID_BITS-1:0]   cols_reg;
    logic [GRID_BITS-1:0]   rows_reg;
    logic [OFFSET_BITS-1:0] off_x_reg;
    logic [OFFSET_BITS-1:0] off_y_reg;
    logic                   outline_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cell_w_reg  <= DIM_BITS'(8);
            cell_h_reg  <= DIM_BITS'(16);
            cols_reg    <= GRID_BITS'(80);
            rows_reg    <= GRID_BITS'(30);
            off_x_reg   <= '0;
            off_y_reg   <= '0;
            outline_reg <= 1'b1;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_reg_t'(cfg_index))
                REG_CELL_WIDTH:     cell_w_reg  <= cfg_data[DIM_BITS-1:0];
                REG_CELL_HEIGHT:    cell_h_reg  <= cfg_data[DIM_BITS-1:0];
                REG_GRID_COLUMNS:   cols_reg    <= cfg_data[GRID_BITS-1:0];
                REG_GRID_ROWS:      rows_reg    <= cfg_data[GRID_BITS-1:0];
                REG_OFFSET_X:       off_x_reg   <= cfg_data[OFFSET_BITS-1:0];
                REG_OFFSET_Y:       off_y_reg   <= cfg_data[OFFSET_BITS-1:0];
                REG_OUTLINE_ENABLE: outline_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // zero acts as one, oversize values saturate
    always_comb begin
        cfg.cell_w = (cell_w_reg == '0) ? DIM_BITS'(1) :
                     (cell_w_reg > DIM_BITS'(MAX_CELL_DIM)) ? DIM_BITS'(MAX_CELL_DIM) :
                     cell_w_reg;
        cfg.cell_h = (cell_h_reg == '0) ? DIM_BITS'(1) :
                     (cell_h_reg > DIM_BITS'(MAX_CELL_DIM)) ? DIM_BITS'(MAX_CELL_DIM) :
                     cell_h_reg;
        cfg.cols   = (cols_reg == '0) ? GRID_BITS'(1) :
                     (cols_reg > GRID_BITS'(MAX_COLUMNS)) ? GRID_BITS'(MAX_COLUMNS) :
                     cols_reg;
        cfg.rows   = (rows_reg == '0) ? GRID_BITS'(1) :
                     (rows_reg > GRID_BITS'(MAX_COLUMNS)) ? GRID_BITS'(MAX_COLUMNS) :
                     rows_reg;
        cfg.off_x   = off_x_reg;
        cfg.off_y   = off_y_reg;
        cfg.outline = outline_reg;
    end

endmodule

// ----- rtl/pcas_div.sv -----
// bit-serial restoring divider, coordinate by cell dimension
module pcas_div (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             start,
    input  logic [pcas_pkg::COORD_BITS-1:0]  dividend,
    input  logic [pcas_pkg::DIM_BITS-1:0]    divisor,
    output logic                             busy,
    output logic [pcas_pkg::COORD_BITS-1:0]  quotient,
    output logic [pcas_pkg::DIM_BITS-1:0]    remainder
);
    import pcas_pkg::*;

    localparam int STEP_BITS = $clog2(COORD_BITS + 1);

    logic [COORD_BITS-1:0] quo_reg;
    logic [DIM_BITS-1:0]   rem_reg;
    logic [DIM_BITS-1:0]   dvs_reg;
    logic [STEP_BITS-1:0]  step_reg;
    logic                  busy_reg;

    logic [DIM_BITS:0]     trial;
    logic                  fits;
    logic [DIM_BITS-1:0]   rem_next;

    always_comb begin
        trial    = {rem_reg, quo_reg[COORD_BITS-1]};
        fits     = trial >= {1'b0, dvs_reg};
        rem_next = fits ? DIM_BITS'(trial - {1'b0, dvs_reg}) : trial[DIM_BITS-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            step_reg <= STEP_BITS'(COORD_BITS);
        end else if (busy_reg) begin
            step_reg <= step_reg - STEP_BITS'(1);
            if (step_reg == STEP_BITS'(1)) begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end else if (busy_reg) begin
            quo_reg <= {quo_reg[COORD_BITS-2:0], fits};
            rem_reg <= rem_next;
        end
    end

    assign busy      = busy_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

// ----- rtl/pcas_mem.sv -----
// per-column accumulator memory, one write and one registered read port
module pcas_mem (
    input  logic                                aclk,
    input  logic                                wr_en,
    input  logic [pcas_pkg::CELL_IDX_BITS-1:0]  wr_addr,
    input  pcas_pkg::acc_t                      wr_data,
    input  logic                                rd_en,
    input  logic [pcas_pkg::CELL_IDX_BITS-1:0]  rd_addr,
    output pcas_pkg::acc_t                      rd_data
);
    import pcas_pkg::*;

    acc_t mem [MAX_COLUMNS];
    acc_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/pixel_cell_to_ascii_shade_core.sv -----
// top level: pixel stream in, one shade character per finished grid cell out
// Each accepted pixel is located in the character grid by two 12-step bit-serial dividers
// (column and row run side by side), then its grid column's accumulator is read from the
// 256-entry memory, updated and written back. A new pixel is taken only once the core is
// back in idle: after the write-back when the pixel does not finish a cell, after the shade
// threshold and the character lookup as well when it does, and right after the divide for
// a pixel outside the grid. Pixels outside the grid produce no word. The result sits in an
// output register, so a pixel can be taken while the previous character waits on m_tready;
// a finished cell only holds the core in its lookup step while that register is still
// full. Accumulators hold no reset value: a cell whose top-left pixel never arrived gives
// an unspecified character.
module pixel_cell_to_ascii_shade_core (
    input  logic                                aclk,
    input  logic                                aresetn,
    // pixel_x [11:0], pixel_y [23:12], gray_level [31:24]
    input  logic [31:0]                         s_tdata,
    // edge_flag
    input  logic                                s_tuser,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // char_code [6:0], cell_column [14:7], cell_row [22:15], zero [23]
    output logic [23:0]                         m_tdata,
    // frame_last
    output logic                                m_tlast,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [pcas_pkg::CFG_IDX_BITS-1:0]   cfg_index,
    input  logic [pcas_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
    import pcas_pkg::*;

    cfg_t cfg;

    state_t state_reg, state_next;

    logic [COORD_BITS-1:0] pix_x, pix_y, dx, dy;
    logic [GRAY_BITS-1:0]  pix_gray;
    logic                  accept, outside;

    logic                  div_x_busy, div_y_busy;
    logic [COORD_BITS-1:0] quo_x, quo_y;
    logic [DIM_BITS-1:0]   rem_x, rem_y;

    logic [GRAY_BITS-1:0]     gray_reg;
    logic                     edge_reg;
    logic                     outside_reg;
    logic [CELL_IDX_BITS-1:0] col_reg, row_reg;
    logic                     start_reg, end_reg, last_reg;
    logic [AREA_BITS-1:0]     area_reg;
    logic [SUM_BITS-1:0]      thr_reg;
    logic [SUM_BITS-1:0]      sum_reg;
    logic [CNT_BITS-1:0]      cnt_reg;

    logic [23:0] m_tdata_reg;
    logic        m_tlast_reg, m_tvalid_reg;

    logic        in_grid, divs_done;
    logic        mem_rd_en, mem_wr_en;
    acc_t        mem_rd_data, acc_new;
    logic        load_out;

    logic [SUM_BITS:0]    thr2, thr3;
    logic [1:0]           shade_idx;
    logic [CHAR_BITS-1:0] code;

    pcas_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    assign pix_x    = s_tdata[COORD_BITS-1:0];
    assign pix_y    = s_tdata[2*COORD_BITS-1:COORD_BITS];
    assign pix_gray = s_tdata[2*COORD_BITS+GRAY_BITS-1:2*COORD_BITS];
    assign accept   = s_tvalid && s_tready;
    assign outside  = (pix_x < COORD_BITS'(cfg.off_x)) || (pix_y < COORD_BITS'(cfg.off_y));
    assign dx       = pix_x - COORD_BITS'(cfg.off_x);
    assign dy       = pix_y - COORD_BITS'(cfg.off_y);

    pcas_div u_div_x (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (accept),
        .dividend  (dx),
        .divisor   (cfg.cell_w),
        .busy      (div_x_busy),
        .quotient  (quo_x),
        .remainder (rem_x)
    );

    pcas_div u_div_y (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (accept),
        .dividend  (dy),
        .divisor   (cfg.cell_h),
        .busy      (div_y_busy),
        .quotient  (quo_y),
        .remainder (rem_y)
    );

    assign divs_done = !div_x_busy && !div_y_busy;
    assign in_grid   = !outside_reg &&
                       (quo_x < COORD_BITS'(cfg.cols)) && (quo_y < COORD_BITS'(cfg.rows));

    // top-left pixel reloads, every other pixel of the cell adds
    always_comb begin
        acc_new.sum = start_reg ? SUM_BITS'(gray_reg)
                                : mem_rd_data.sum + SUM_BITS'(gray_reg);
        acc_new.cnt = start_reg ? CNT_BITS'(edge_reg)
                                : mem_rd_data.cnt + CNT_BITS'(edge_reg);
    end

    pcas_mem u_mem (
        .aclk    (aclk),
        .wr_en   (mem_wr_en),
        .wr_addr (col_reg),
        .wr_data (acc_new),
        .rd_en   (mem_rd_en),
        .rd_addr (quo_x[CELL_IDX_BITS-1:0]),
        .rd_data (mem_rd_data)
    );

    // average / 63 >= k is the same as sum >= 63 * k * area
    always_comb begin
        thr2 = {thr_reg, 1'b0};
        thr3 = thr2 + {1'b0, thr_reg};
        if ({1'b0, sum_reg} >= thr3) begin
            shade_idx = 2'd3;
        end else if ({1'b0, sum_reg} >= thr2) begin
            shade_idx = 2'd2;
        end else if (sum_reg >= thr_reg) begin
            shade_idx = 2'd1;
        end else begin
            shade_idx = 2'd0;
        end
        code = (cfg.outline && cnt_reg > CNT_BITS'(1)) ? CHAR_OUTLINE : shade_code(shade_idx);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        s_tready   = 1'b0;
        mem_rd_en  = 1'b0;
        mem_wr_en  = 1'b0;
        load_out   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                if (divs_done) begin
                    if (in_grid) begin
                        mem_rd_en  = 1'b1;
                        state_next = ST_READ;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_READ: begin
                mem_wr_en  = 1'b1;
                state_next = end_reg ? ST_THRESH : ST_IDLE;
            end
            ST_THRESH: begin
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (!m_tvalid_reg || m_tready) begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            gray_reg    <= pix_gray;
            edge_reg    <= s_tuser;
            outside_reg <= outside;
        end
        if (state_reg == ST_DIV && divs_done) begin
            col_reg   <= quo_x[CELL_IDX_BITS-1:0];
            row_reg   <= quo_y[CELL_IDX_BITS-1:0];
            start_reg <= (rem_x == '0) && (rem_y == '0);
            end_reg   <= (rem_x == cfg.cell_w - DIM_BITS'(1)) &&
                         (rem_y == cfg.cell_h - DIM_BITS'(1));
            last_reg  <= (quo_x == COORD_BITS'(cfg.cols - GRID_BITS'(1))) &&
                         (quo_y == COORD_BITS'(cfg.rows - GRID_BITS'(1)));
            area_reg  <= AREA_BITS'(cfg.cell_w) * AREA_BITS'(cfg.cell_h);
        end
        if (mem_wr_en) begin
            sum_reg <= acc_new.sum;
            cnt_reg <= acc_new.cnt;
        end
        if (state_reg == ST_THRESH) begin
            thr_reg <= SUM_BITS'(area_reg) * SHADE_STEP;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (load_out) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            m_tdata_reg <= {1'b0, row_reg, col_reg, code};
            m_tlast_reg <= last_reg;
        end
    end

    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tvalid = m_tvalid_reg;

    // a taken pixel starts both dividers together
    assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> (div_x_busy && div_y_busy))
        else $error("dividers not started on accepted pixel");

    // the accumulator is only read for a column inside the grid
    assert property (@(posedge aclk) disable iff (!aresetn)
        mem_rd_en |-> (quo_x < COORD_BITS'(cfg.cols)) && !outside_reg)
        else $error("accumulator read outside the grid");

    // a new word only appears after the character lookup step
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(state_reg == ST_EMIT))
        else $error("output word loaded outside emit step");

    // write-back happens the cycle after the read, never while the dividers run
    assert property (@(posedge aclk) disable iff (!aresetn)
        mem_wr_en |-> $past(mem_rd_en) && divs_done)
        else $error("accumulator write without preceding read");

endmodule
